// File: hw/rtl/dsdiff_pkg.sv
// package: phase codes, chunk ids and shared types for the dsdiff parser
`default_nettype none
package dsdiff_pkg;
  localparam logic [31:0] ID_FRM8 = 32'h46524D38;
  localparam logic [31:0] ID_DSD  = 32'h44534420;
  localparam logic [31:0] ID_PROP = 32'h50524F50;
  localparam logic [31:0] ID_SND  = 32'h534E4420;
  localparam logic [31:0] ID_FS   = 32'h46532020;
  localparam logic [31:0] ID_CHNL = 32'h43484E4C;
  localparam logic [31:0] ID_CMPR = 32'h434D5052;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_AUDIO  = 2'd1;
  localparam logic [1:0] KIND_FORMAT = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam int SIZE_W = 64;
  localparam int CNT_W  = 16;

  typedef enum logic [2:0] {
    PH_FORM, PH_TOP_HDR, PH_PROP_ID, PH_SND_HDR, PH_SND_BODY, PH_SKIP, PH_DSD_DATA
  } phase_t;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} seq_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  audio_byte;
    logic [15:0] channel_index;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic        finished;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;
endpackage
`default_nettype wire

// File: hw/rtl/dsdiff_if.sv
// request and result channel interfaces with valid/ready handshake
`default_nettype none
interface dsdiff_in_if;
  logic                 valid;
  logic                 ready;
  dsdiff_pkg::item_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dsdiff_out_if;
  logic                 valid;
  logic                 ready;
  dsdiff_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/dsdiff_mod.sv
// restoring remainder unit: one quotient bit per cycle, 64-bit dividend
`default_nettype none
module dsdiff_mod #(
  parameter int SizeW = dsdiff_pkg::SIZE_W,
  parameter int CntW  = dsdiff_pkg::CNT_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SizeW-1:0] dividend,
  input  wire logic [CntW-1:0]  divisor,
  output logic                  done,
  output logic [CntW-1:0]       remainder
);
  import dsdiff_pkg::*;
  localparam int StepW = $clog2(SizeW + 1);

  logic [SizeW-1:0] shreg;
  logic [CntW:0]    rem;
  logic [CntW-1:0]  dvs;
  logic [StepW-1:0] steps;
  logic             busy;
  logic [CntW:0]    trial;

  // one shift-and-subtract step
  always_comb begin
    trial = {rem[CntW-1:0], shreg[SizeW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= StepW'(SizeW);
        shreg <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        shreg <= shreg << 1;
        rem   <= (trial >= {1'b0, dvs}) ? trial - {1'b0, dvs} : trial;
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[CntW-1:0];
endmodule
`default_nettype wire

// File: hw/rtl/dsdiff_container_parser_top.sv
// top level: byte-wise dsdiff container parser
// latency: the result is offered the cycle after its request is taken; a dsd chunk
//   header byte with a nonzero channel count holds it until the remainder unit is done
// the result register frees once taken; a new request waits for it
// reset (rst, synchronous): parser returns to form header, stores clear
`default_nettype none
module dsdiff_container_parser_top #(
  parameter int SizeW = dsdiff_pkg::SIZE_W,
  parameter int CntW  = dsdiff_pkg::CNT_W
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_wdata,
  dsdiff_in_if.sink    in_ch,
  dsdiff_out_if.source out_ch
);
  import dsdiff_pkg::*;

  seq_t seq, seq_next;
  logic lsb_first;

  phase_t            phase, phase_next;
  logic [3:0]        hcnt, hcnt_next;
  logic [31:0]       cid, cid_next;
  logic [SizeW-1:0]  csize, csize_next;
  logic [SizeW-1:0]  cleft, cleft_next;
  logic [SizeW-1:0]  pleft, pleft_next;
  logic [SizeW-1:0]  eleft, eleft_next;
  logic [31:0]       pshift, pshift_next;
  logic [31:0]       srate, srate_next;
  logic [CntW-1:0]   ccount, ccount_next;
  logic [CntW-1:0]   fpos, fpos_next;
  logic              freported, freported_next;
  logic              stopped, stopped_next;
  result_t           res, res_next;
  item_t             item;
  logic              need_div;
  logic              div_start, div_done;
  logic [CntW-1:0]   div_rem;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) lsb_first <= 1'b0;
    else if (cfg_we) lsb_first <= cfg_wdata[0];
  end

  assign item = in_ch.data;

  // byte step of the parser
  always_comb begin
    logic       err;
    logic [1:0] kind;
    logic [7:0] ab;
    logic [CntW-1:0] cidx;
    logic [2:0] need;
    logic [SizeW-1:0] pl;
    logic [31:0] ps;
    err = 1'b0; kind = KIND_NONE; ab = '0; cidx = '0; need = '0; pl = '0; ps = '0;
    need_div = 1'b0;
    phase_next = phase; hcnt_next = hcnt; cid_next = cid; csize_next = csize;
    cleft_next = cleft; pleft_next = pleft; eleft_next = eleft; pshift_next = pshift;
    srate_next = srate; ccount_next = ccount; fpos_next = fpos;
    freported_next = freported; stopped_next = stopped;
    if (!stopped) begin
      unique case (phase)
        PH_FORM: begin
          if (hcnt < 4'd4) cid_next = {cid[23:0], item.data_byte};
          else if (hcnt >= 4'd12) pshift_next = {pshift[23:0], item.data_byte};
          if (hcnt == 4'd15) begin
            if (cid_next != ID_FRM8 || pshift_next != ID_DSD) err = 1'b1;
            else begin phase_next = PH_TOP_HDR; hcnt_next = '0; end
          end else hcnt_next = hcnt + 4'd1;
        end
        PH_TOP_HDR: begin
          if (hcnt < 4'd4) cid_next = {cid[23:0], item.data_byte};
          else csize_next = {csize[SizeW-9:0], item.data_byte};
          if (hcnt != 4'd11) hcnt_next = hcnt + 4'd1;
          else begin
            hcnt_next = '0;
            if (cid_next == ID_DSD) begin
              if (!freported && (ccount == '0 || srate == '0)) err = 1'b1;
              else begin
                if (!freported) begin kind = KIND_FORMAT; freported_next = 1'b1; end
                cleft_next = csize_next;
                eleft_next = csize_next;
                need_div = (ccount != '0);
                if (ccount == '0) eleft_next = '0;
                fpos_next = '0;
                phase_next = (csize_next != '0) ? PH_DSD_DATA : PH_TOP_HDR;
              end
            end else if (cid_next == ID_PROP && !freported) begin
              if (csize_next < SizeW'(4)) err = 1'b1;
              else begin
                cleft_next = csize_next; pshift_next = '0; phase_next = PH_PROP_ID;
              end
            end else begin
              cleft_next = csize_next;
              phase_next = (csize_next != '0) ? PH_SKIP : PH_TOP_HDR;
            end
          end
        end
        PH_PROP_ID: begin
          ps = {pshift[23:0], item.data_byte};
          pshift_next = ps;
          if (hcnt != 4'd3) hcnt_next = hcnt + 4'd1;
          else begin
            hcnt_next = '0;
            pl = cleft - SizeW'(4);
            pleft_next = pl;
            if (ps == ID_SND) begin
              if (pl == '0) phase_next = PH_TOP_HDR;
              else if (pl < SizeW'(12)) err = 1'b1;
              else phase_next = PH_SND_HDR;
            end else begin
              cleft_next = pl;
              phase_next = (pl != '0) ? PH_SKIP : PH_TOP_HDR;
            end
          end
        end
        PH_SND_HDR: begin
          if (hcnt < 4'd4) cid_next = {cid[23:0], item.data_byte};
          else csize_next = {csize[SizeW-9:0], item.data_byte};
          pl = pleft - SizeW'(1);
          pleft_next = pl;
          if (hcnt != 4'd11) hcnt_next = hcnt + 4'd1;
          else begin
            hcnt_next = '0;
            if (csize_next > pl ||
                (cid_next == ID_FS && csize_next != SizeW'(4)) ||
                (cid_next == ID_CHNL && csize_next < SizeW'(2)) ||
                (cid_next == ID_CMPR && csize_next < SizeW'(4))) err = 1'b1;
            else begin
              cleft_next = csize_next; pshift_next = '0;
              if (csize_next == '0) begin
                if (pl == '0) phase_next = PH_TOP_HDR;
                else if (pl < SizeW'(12)) err = 1'b1;
                else phase_next = PH_SND_HDR;
              end else phase_next = PH_SND_BODY;
            end
          end
        end
        PH_SND_BODY: begin
          if (cid == ID_FS || cid == ID_CMPR) need = 3'd4;
          else if (cid == ID_CHNL) need = 3'd2;
          pl = pleft - SizeW'(1);
          pleft_next = pl;
          cleft_next = cleft - SizeW'(1);
          if (hcnt < {1'b0, need}) begin
            ps = {pshift[23:0], item.data_byte};
            pshift_next = ps;
            hcnt_next = hcnt + 4'd1;
            if (hcnt_next == {1'b0, need}) begin
              if (cid == ID_FS) srate_next = ps;
              else if (cid == ID_CHNL) ccount_next = ps[CntW-1:0];
              else if (ps != ID_DSD) err = 1'b1;
            end
          end
          if (!err && cleft_next == '0) begin
            hcnt_next = '0;
            if (pl == '0) phase_next = PH_TOP_HDR;
            else if (pl < SizeW'(12)) err = 1'b1;
            else phase_next = PH_SND_HDR;
          end
        end
        PH_SKIP: begin
          cleft_next = cleft - SizeW'(1);
          if (cleft_next == '0) begin phase_next = PH_TOP_HDR; hcnt_next = '0; end
        end
        PH_DSD_DATA: begin
          if (eleft != '0) begin
            kind = KIND_AUDIO;
            ab = lsb_first ? {<<{item.data_byte}} : item.data_byte;
            cidx = fpos;
            fpos_next = (fpos + 1'b1 >= ccount) ? '0 : fpos + 1'b1;
            eleft_next = eleft - SizeW'(1);
          end
          cleft_next = cleft - SizeW'(1);
          if (cleft_next == '0) begin phase_next = PH_TOP_HDR; hcnt_next = '0; end
        end
        default: err = 1'b1;
      endcase
      if (err) begin
        kind = KIND_ERROR; ab = '0; cidx = '0; stopped_next = 1'b1; need_div = 1'b0;
      end else if (item.last_byte) begin
        if (!freported_next) kind = KIND_ERROR;
        stopped_next = 1'b1;
      end
    end
    res_next.kind          = kind;
    res_next.audio_byte    = ab;
    res_next.channel_index = cidx;
    res_next.rate_hz       = srate_next;
    res_next.channel_count = ccount_next;
    res_next.finished      = stopped_next;
  end

  // sequencer next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      ST_IDLE: if (in_ch.valid) seq_next = need_div ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_done) seq_next = ST_OUT;
      ST_OUT:  if (out_ch.ready) seq_next = ST_IDLE;
      default: seq_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready  = (seq == ST_IDLE);
    out_ch.valid = (seq == ST_OUT);
    div_start    = (seq == ST_IDLE) && in_ch.valid && need_div;
  end

  assign out_ch.data = res;

  dsdiff_mod #(.SizeW(SizeW), .CntW(CntW)) u_mod (
    .clk(clk), .rst(rst), .start(div_start), .dividend(csize_next),
    .divisor(ccount), .done(div_done), .remainder(div_rem)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= ST_IDLE; phase <= PH_FORM; hcnt <= '0; cid <= '0; csize <= '0;
      cleft <= '0; pleft <= '0; eleft <= '0; pshift <= '0; srate <= '0;
      ccount <= '0; fpos <= '0; freported <= 1'b0; stopped <= 1'b0;
    end else begin
      seq <= seq_next;
      if (seq == ST_IDLE && in_ch.valid) begin
        phase <= phase_next; hcnt <= hcnt_next; cid <= cid_next; csize <= csize_next;
        cleft <= cleft_next; pleft <= pleft_next; eleft <= eleft_next;
        pshift <= pshift_next; srate <= srate_next; ccount <= ccount_next;
        fpos <= fpos_next; freported <= freported_next; stopped <= stopped_next;
        res <= res_next;
      end else if (seq == ST_DIV && div_done) begin
        eleft <= eleft - SizeW'(div_rem);
      end
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (seq != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(stopped) && !$past(rst) |-> stopped) else $error("stop cleared");
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    div_done |-> seq == ST_DIV) else $error("stray remainder result");
endmodule
`default_nettype wire

// File: sim/tb.sv
// testbench for the dsdiff container parser: byte-stream driver, scoreboard and predictor
`timescale 1ns / 100ps
module tb;
  import dsdiff_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_wdata;

  dsdiff_in_if  in_ch ();
  dsdiff_out_if out_ch ();

  dsdiff_container_parser_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // byte stream waiting to go in, parser results still owed
  item_t   file_bytes[$];
  result_t owed_results[$];

  int gap_pct;
  int stall_pct;
  bit hold_tx;
  bit offered;
  int errors;
  int bytes_taken;
  int audio_seen;
  int format_seen;
  int error_seen;

  // predicted parser state
  phase_t      p_phase;
  logic [3:0]  p_hcnt;
  logic [31:0] p_id;
  logic [63:0] p_size;
  logic [63:0] p_left;
  logic [63:0] p_prop_left;
  logic [63:0] p_emit_left;
  logic [31:0] p_word;
  logic [31:0] p_rate;
  logic [15:0] p_chans;
  logic [15:0] p_fpos;
  logic        p_fmt_done;
  logic        p_stopped;
  logic        p_lsb_first;

  function automatic void goto_top_header();
    p_phase = PH_TOP_HDR;
    p_hcnt  = '0;
  endfunction

  // next step inside a SND property: another sub-chunk, back to the top, or a stray tail
  function automatic bit snd_advance();
    if (p_prop_left == 0) begin
      goto_top_header();
      return 1'b0;
    end
    if (p_prop_left < 12) return 1'b1;
    p_phase = PH_SND_HDR;
    p_hcnt  = '0;
    return 1'b0;
  endfunction

  // predict the result of one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [1:0]  k;
    logic [7:0]  ab;
    logic [15:0] ci;
    bit          err;
    int unsigned need;
    result_t     r;
    k = KIND_NONE;
    ab = '0;
    ci = '0;
    err = 1'b0;
    if (!p_stopped) begin
      case (p_phase)
        PH_FORM: begin
          if (p_hcnt < 4) p_id = {p_id[23:0], b};
          else if (p_hcnt >= 12) p_word = {p_word[23:0], b};
          if (p_hcnt == 15) begin
            if (p_id != ID_FRM8 || p_word != ID_DSD) err = 1'b1;
            else goto_top_header();
          end else begin
            p_hcnt++;
          end
        end
        PH_TOP_HDR: begin
          if (p_hcnt < 4) p_id = {p_id[23:0], b};
          else p_size = {p_size[55:0], b};
          if (p_hcnt != 11) begin
            p_hcnt++;
          end else begin
            p_hcnt = '0;
            if (p_id == ID_DSD) begin
              if (!p_fmt_done && (p_chans == 0 || p_rate == 0)) begin
                err = 1'b1;
              end else begin
                if (!p_fmt_done) begin
                  k = KIND_FORMAT;
                  p_fmt_done = 1'b1;
                end
                p_left = p_size;
                p_emit_left = (p_chans != 0) ? p_size - (p_size % p_chans) : 64'd0;
                p_fpos = '0;
                p_phase = (p_left != 0) ? PH_DSD_DATA : PH_TOP_HDR;
              end
            end else if (p_id == ID_PROP && !p_fmt_done) begin
              if (p_size < 4) begin
                err = 1'b1;
              end else begin
                p_left = p_size;
                p_word = '0;
                p_phase = PH_PROP_ID;
              end
            end else begin
              p_left = p_size;
              p_phase = (p_left != 0) ? PH_SKIP : PH_TOP_HDR;
            end
          end
        end
        PH_PROP_ID: begin
          p_word = {p_word[23:0], b};
          if (p_hcnt != 3) begin
            p_hcnt++;
          end else begin
            p_hcnt = '0;
            p_prop_left = p_left - 4;
            if (p_word == ID_SND) begin
              err = snd_advance();
            end else begin
              p_left = p_prop_left;
              p_phase = (p_left != 0) ? PH_SKIP : PH_TOP_HDR;
            end
          end
        end
        PH_SND_HDR: begin
          if (p_hcnt < 4) p_id = {p_id[23:0], b};
          else p_size = {p_size[55:0], b};
          p_prop_left--;
          if (p_hcnt != 11) begin
            p_hcnt++;
          end else begin
            p_hcnt = '0;
            if (p_size > p_prop_left || (p_id == ID_FS && p_size != 4) ||
                (p_id == ID_CHNL && p_size < 2) || (p_id == ID_CMPR && p_size < 4)) begin
              err = 1'b1;
            end else begin
              p_left = p_size;
              p_word = '0;
              if (p_left == 0) err = snd_advance();
              else p_phase = PH_SND_BODY;
            end
          end
        end
        PH_SND_BODY: begin
          need = (p_id == ID_FS || p_id == ID_CMPR) ? 4 : (p_id == ID_CHNL) ? 2 : 0;
          p_prop_left--;
          p_left--;
          if (p_hcnt < need) begin
            p_word = {p_word[23:0], b};
            p_hcnt++;
            if (p_hcnt == need) begin
              if (p_id == ID_FS) p_rate = p_word;
              else if (p_id == ID_CHNL) p_chans = p_word[15:0];
              else if (p_word != ID_DSD) err = 1'b1;
            end
          end
          if (!err && p_left == 0) err = snd_advance();
        end
        PH_SKIP: begin
          p_left--;
          if (p_left == 0) goto_top_header();
        end
        PH_DSD_DATA: begin
          if (p_emit_left != 0) begin
            k = KIND_AUDIO;
            for (int i = 0; i < 8; i++) ab[i] = p_lsb_first ? b[7 - i] : b[i];
            ci = p_fpos;
            p_fpos++;
            if (p_fpos >= p_chans) p_fpos = '0;
            p_emit_left--;
          end
          p_left--;
          if (p_left == 0) goto_top_header();
        end
        default: err = 1'b1;
      endcase
      if (err) begin
        k = KIND_ERROR;
        ab = '0;
        ci = '0;
        p_stopped = 1'b1;
      end else if (last) begin
        if (!p_fmt_done) k = KIND_ERROR;
        p_stopped = 1'b1;
      end
    end
    r.kind = k;
    r.audio_byte = ab;
    r.channel_index = ci;
    r.rate_hz = p_rate;
    r.channel_count = p_chans;
    r.finished = p_stopped;
    owed_results.push_back(r);
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    errors++;
  endtask

  // stream building
  task automatic put_byte(input logic [7:0] b, input logic last = 1'b0);
    item_t it;
    it.data_byte = b;
    it.last_byte = last;
    file_bytes.push_back(it);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8]);
  endtask

  task automatic put_header(input logic [31:0] id, input logic [63:0] size);
    put_word(id);
    put_word(size[63:32]);
    put_word(size[31:0]);
  endtask

  task automatic put_noise(input int count);
    for (int i = 0; i < count; i++) put_byte(8'($urandom));
  endtask

  // driver: offers the next byte at the falling edge, holds it until taken
  always @(negedge clk) begin
    if (!offered) begin
      if (!rst && !hold_tx && file_bytes.size() > 0 && $urandom_range(99) >= gap_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= file_bytes[0];
        offered = 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready && offered) begin
      parse_byte(file_bytes[0].data_byte, file_bytes[0].last_byte);
      void'(file_bytes.pop_front());
      offered = 1'b0;
      bytes_taken++;
    end
  end

  // monitor: compare every taken result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (owed_results.size() == 0) begin
        $display("[%0t] result with nothing predicted: %h", $realtime, got);
        errors++;
      end else begin
        want = owed_results.pop_front();
        if (got.kind != want.kind) report("kind", got.kind, want.kind);
        if (got.audio_byte != want.audio_byte)
          report("audio_byte", got.audio_byte, want.audio_byte);
        if (got.channel_index != want.channel_index)
          report("channel_index", got.channel_index, want.channel_index);
        if (got.rate_hz != want.rate_hz)
          report("rate_hz", got.rate_hz, want.rate_hz);
        if (got.channel_count != want.channel_count)
          report("channel_count", got.channel_count, want.channel_count);
        if (got.finished != want.finished) report("finished", got.finished, want.finished);
        case (want.kind)
          KIND_AUDIO:  audio_seen++;
          KIND_FORMAT: format_seen++;
          KIND_ERROR:  error_seen++;
          default: ;
        endcase
      end
    end
  end

  // sender runs until every byte is taken and every owed result is in, then holds while the parser settles
  task automatic drain();
    hold_tx = 1'b0;
    while (file_bytes.size() > 0 || offered || owed_results.size() > 0) @(posedge clk);
    hold_tx = 1'b1;
    repeat (80) @(posedge clk);
  endtask

  task automatic write_lsb_first(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    p_lsb_first = v;
  endtask

  // main sequence
  initial begin
    int phase_bytes;
    int pick;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    hold_tx = 1'b1;
    offered = 1'b0;
    errors = 0;
    bytes_taken = 0;
    audio_seen = 0;
    format_seen = 0;
    error_seen = 0;
    p_phase = PH_FORM;
    p_hcnt = '0;
    p_id = '0;
    p_size = '0;
    p_left = '0;
    p_prop_left = '0;
    p_emit_left = '0;
    p_word = '0;
    p_rate = '0;
    p_chans = '0;
    p_fpos = '0;
    p_fmt_done = 1'b0;
    p_stopped = 1'b0;
    p_lsb_first = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_lsb_first(1'b1);

    // directed file start: form header, skipped and parsed properties, partial frame
    put_header(ID_FRM8, {$urandom, $urandom});
    put_word(ID_DSD);
    put_header(ID_PROP, 64'd6);
    put_word(32'h41424344);
    put_noise(2);
    put_header(ID_PROP, 64'd62);
    put_word(ID_SND);
    put_header(ID_FS, 64'd4);
    put_word(32'hFFFF_FFFF);
    put_header(ID_CHNL, 64'd2);
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_header(ID_CMPR, 64'd4);
    put_word(ID_DSD);
    put_header(32'h41424344, 64'd0);
    put_header(32'h58595A20, 64'd0);
    put_header(32'h58595A21, 64'd3);
    put_noise(3);
    // second property sets a small channel count; extra payload bytes on the channel and compression fields
    put_header(ID_PROP, 64'd55);
    put_word(ID_SND);
    put_header(ID_FS, 64'd4);
    put_word($urandom_range(32'h7FFF_FFFF, 1));
    put_header(ID_CHNL, 64'd5);
    put_byte(8'h00);
    put_byte(8'($urandom_range(6, 1)));
    put_noise(3);
    put_header(ID_CMPR, 64'd6);
    put_word(ID_DSD);
    put_noise(2);
    put_header(ID_DSD, 64'd7);
    put_noise(7);
    put_header(ID_PROP, 64'd4);
    put_word(ID_SND);
    put_header(ID_DSD, 64'd0);
    drain();

    // random phases over idling patterns and both bit orders
    for (int ph = 0; ph < 8; ph++) begin
      write_lsb_first(ph[0]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 58; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 220) begin
        pick = $urandom_range(9);
        if (pick < 7) begin
          pick = $urandom_range(40);
          put_header(ID_DSD, 64'(pick));
        end else if (pick < 9) begin
          pick = $urandom_range(10);
          put_header($urandom, 64'(pick));
        end else begin
          pick = $urandom_range(12, 4);
          put_header(ID_PROP, 64'(pick));
        end
        put_noise(pick);
        phase_bytes += 12 + pick;
      end
      drain();
    end

    // end of file mid-data or mid-header, then bytes that must be ignored
    gap_pct = 20;
    stall_pct = 20;
    put_header(ID_DSD, 64'd20);
    put_noise($urandom_range(10, 1));
    if ($urandom_range(1)) begin
      put_byte(8'($urandom), 1'b1);
    end else begin
      put_header($urandom, 64'd4);
      put_noise(4);
      put_byte(8'h44, 1'b1);
    end
    put_noise(3);
    put_byte(8'($urandom), 1'b1);
    drain();

    $display("covered %0d file bytes: %0d audio bytes, %0d format reports, %0d error results",
             bytes_taken, audio_seen, format_seen, error_seen);
    $display("eight random phases across gap and stall patterns, both bit orders");
    if (errors == 0) begin
      $display("dsdiff_container_parser_top test passed");
    end else begin
      $display("dsdiff_container_parser_top test failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #12000000;
    $display("dsdiff_container_parser_top test failed");
    $finish;
  end
endmodule
